>>> src/prltp_pkg.sv
// ----------------------------------------------------------------------------
// prltp_pkg: shared types and constants of the launch-time pacer
// Item structs, command and mode codes, register indexes and the
// controller-to-datapath command and status groups.
// ----------------------------------------------------------------------------
package prltp_pkg;

  localparam int RULE_COUNT_DEF = 8;
  localparam int ADDR_W         = 3;
  localparam int DATA_W         = 32;

  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  typedef enum logic [0:0] {
    CMD_CLASSIFY   = 1'b0,
    CMD_WRITE_RULE = 1'b1
  } cmd_code_t;

  typedef enum logic [1:0] {
    MODE_NORMAL  = 2'd0,
    MODE_BEFORE  = 2'd1,
    MODE_BEYOND  = 2'd2,
    MODE_REVERSE = 2'd3
  } ts_mode_t;

  typedef enum logic [0:0] {
    REG_MODE    = 1'b0,
    REG_HORIZON = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    cmd_code_t   command;
    logic        is_ipv4;
    logic [7:0]  ip_protocol;
    logic [15:0] dest_port;
    logic [63:0] current_time;
    logic [2:0]  rule_slot;
    logic [15:0] rule_port_value;
    logic [31:0] rule_pacing_ns;
  } in_item_t;

  typedef struct packed {
    logic        launch_valid;
    logic [63:0] launch_time;
    logic [2:0]  hit_rule;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic search;
    logic emit_zero;
    logic emit_hit;
  } dp_cmd_t;

  typedef struct packed {
    logic classify_hit;
    logic out_free;
  } dp_status_t;

endpackage

>>> src/prltp_ctrl.sv
// ----------------------------------------------------------------------------
// prltp_ctrl: sequencing controller of the launch-time pacer
// Steps one item through capture, rule search and the last-time update.
// ----------------------------------------------------------------------------
module prltp_ctrl import prltp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    item_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        item_stall = 1'b0;
        if (item_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (status.classify_hit) begin
          cmd.search = 1'b1;
          state_next = ST_UPDATE;
        end else if (status.out_free) begin
          cmd.emit_zero = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      ST_UPDATE: begin
        if (status.out_free) begin
          cmd.emit_hit = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> src/prltp_dpath.sv
// ----------------------------------------------------------------------------
// prltp_dpath: datapath of the launch-time pacer
// Rule table, priority port search, last-time memory, update arithmetic
// and the result register.
// ----------------------------------------------------------------------------
module prltp_dpath import prltp_pkg::*; #(
  parameter int RULE_COUNT = RULE_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  in_item_t    item,
  input  dp_cmd_t     cmd,
  output dp_status_t  status,
  input  ts_mode_t    mode,
  input  logic [31:0] horizon,
  input  logic        result_stall,
  output logic        result_valid,
  output out_item_t   result
);

  localparam int SLOT_W = (RULE_COUNT > 1) ? $clog2(RULE_COUNT) : 1;

  in_item_t item_r;

  logic [15:0] rule_port [RULE_COUNT];
  logic [31:0] pacing_mem [RULE_COUNT];
  logic [63:0] last_mem [RULE_COUNT];
  logic [RULE_COUNT-1:0] last_vld;

  logic              slot_ok;
  logic [SLOT_W-1:0] wr_slot;

  logic [RULE_COUNT-1:0] nz;
  logic [RULE_COUNT-1:0] match;
  logic [RULE_COUNT-1:0] stop;
  logic [RULE_COUNT-1:0] first_oh;
  logic                  any_hit;
  logic [SLOT_W-1:0]     idx;
  logic                  proto_ok;

  logic [SLOT_W-1:0] hit_idx;
  logic [31:0]       pace_rd;
  logic [63:0]       last_mem_rd;
  logic              last_vld_rd;

  logic [63:0] last_val;
  logic [63:0] pace64;
  logic [63:0] pace20;
  logic [63:0] paced;
  logic [63:0] next_time;

  assign slot_ok = 32'(item.rule_slot) < RULE_COUNT;
  assign wr_slot = SLOT_W'(item.rule_slot);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= item;
    end
  end

  // Rule ports live in flops so that every slot can be compared at once.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < RULE_COUNT; i++) begin
        rule_port[i] <= '0;
      end
    end else if (cmd.capture && item.command == CMD_WRITE_RULE && slot_ok) begin
      rule_port[wr_slot] <= item.rule_port_value;
    end
  end

  // A slot can only hit after its port was written, which writes its pacing
  // too, so the pacing memory needs no clearing.
  always_ff @(posedge clk) begin
    if (cmd.capture && item.command == CMD_WRITE_RULE && slot_ok) begin
      pacing_mem[wr_slot] <= item.rule_pacing_ns;
    end
    if (cmd.search) begin
      pace_rd <= pacing_mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_hit) begin
      last_mem[hit_idx] <= next_time;
    end
    if (cmd.search) begin
      last_mem_rd <= last_mem[idx];
      hit_idx     <= idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_vld <= '0;
    end else if (cmd.emit_hit) begin
      last_vld[hit_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.search) begin
      last_vld_rd <= last_vld[idx];
    end
  end

  // The search ends at the first slot that is empty or matches; the lowest
  // set bit of that stop vector is isolated by a two's complement mask.
  always_comb begin
    idx = '0;
    for (int i = 0; i < RULE_COUNT; i++) begin
      nz[i]    = rule_port[i] != 16'd0;
      match[i] = rule_port[i] == item_r.dest_port;
    end
    stop     = ~nz | match;
    first_oh = stop & (~stop + RULE_COUNT'(1));
    any_hit  = |(first_oh & nz & match);
    for (int i = 0; i < RULE_COUNT; i++) begin
      if (first_oh[i]) begin
        idx = idx | SLOT_W'(i);
      end
    end
  end

  assign proto_ok = item_r.ip_protocol == PROTO_TCP || item_r.ip_protocol == PROTO_UDP;

  assign status.classify_hit = item_r.command == CMD_CLASSIFY && item_r.is_ipv4 &&
                               proto_ok && any_hit;
  assign status.out_free     = !result_valid || !result_stall;

  assign last_val = last_vld_rd ? last_mem_rd : 64'd0;
  assign pace64   = {32'd0, pace_rd};
  assign pace20   = {28'd0, pace_rd, 4'd0} + {30'd0, pace_rd, 2'd0};
  assign paced    = last_val + pace64;

  always_comb begin
    case (mode)
      MODE_NORMAL: begin
        if (last_val == 64'd0) begin
          next_time = item_r.current_time;
        end else begin
          next_time = (paced > item_r.current_time) ? paced : item_r.current_time;
        end
      end
      MODE_BEFORE: begin
        next_time = item_r.current_time - {32'd0, horizon};
      end
      MODE_BEYOND: begin
        next_time = item_r.current_time + {31'd0, horizon, 1'b0};
      end
      MODE_REVERSE: begin
        if (last_val < item_r.current_time) begin
          next_time = item_r.current_time + pace20;
        end else begin
          next_time = last_val - pace64;
        end
      end
      default: begin
        next_time = item_r.current_time;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit_hit || cmd.emit_zero) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_zero) begin
      result <= '0;
    end else if (cmd.emit_hit) begin
      result.launch_valid <= 1'b1;
      result.launch_time  <= next_time;
      result.hit_rule     <= 3'(hit_idx);
    end
  end

endmodule

>>> src/port_rule_launch_time_pacer_unit.sv
// ----------------------------------------------------------------------------
// port_rule_launch_time_pacer_unit: transmit launch-time pacer, top level
// A hit passes through capture, rule search and update before its result
// shows; other items (rule writes, misses, non TCP/UDP) skip the update.
// No new item is taken until the last one has gone to the result
// register, and a result waiting on a stalled receiver holds the block.
// Reset is synchronous: it clears rule ports, last-time valid bits, the
// mode, horizon and controller registers and result_valid; no clearing pass.
// ----------------------------------------------------------------------------
module port_rule_launch_time_pacer_unit import prltp_pkg::*; #(
  parameter int RULE_COUNT = RULE_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  in_item_t          item,
  output logic              result_valid,
  input  logic              result_stall,
  output out_item_t         result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  // The controller accepts an item only when it is idle. A captured item
  // is searched against the rule table in the next cycle; a hit reads the
  // slot's pacing and last launch time into registers, from which the new
  // time is computed, written back and placed in the result register when
  // that register is free. A result waiting on a stalled receiver holds the
  // controller in place, but a finished result never blocks the capture of
  // the next item once it has been loaded.

  ts_mode_t    mode;
  logic [31:0] horizon;
  dp_cmd_t     cmd;
  dp_status_t  status;
  logic        cfg_wr;
  reg_idx_t    reg_idx;

  // Configuration registers. The register index is the word address, and
  // the port never waits.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_NORMAL;
      horizon <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_MODE:    mode    <= ts_mode_t'(pwdata[1:0]);
        REG_HORIZON: horizon <= pwdata[31:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MODE:    prdata = {{(DATA_W-2){1'b0}}, mode};
      REG_HORIZON: prdata = horizon;
      default:     prdata = '0;
    endcase
  end

  // Controller: sequences capture, search and update of one item.
  prltp_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .status     (status),
    .cmd        (cmd)
  );

  // Datapath: rule table, last-time memory, update arithmetic and result.
  prltp_dpath #(
    .RULE_COUNT (RULE_COUNT)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cmd          (cmd),
    .status       (status),
    .mode         (mode),
    .horizon      (horizon),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

>>> src/prltp_checker.sv
// ----------------------------------------------------------------------------
// prltp_checker: port-level checks of the launch-time pacer
// Watches the item and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module prltp_checker import prltp_pkg::*; #(
  parameter int RULE_COUNT = RULE_COUNT_DEF
) (
  input logic      clk,
  input logic      rst,
  input logic      item_valid,
  input logic      item_stall,
  input logic      result_valid,
  input logic      result_stall,
  input out_item_t result
);

  // A result that reports no hit carries no time and no slot.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.launch_valid |->
      result.launch_time == 64'd0 && result.hit_rule == 3'd0)
    else $error("miss result carries nonzero fields");

  // A hit names a slot that exists.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result.launch_valid |-> 32'(result.hit_rule) < RULE_COUNT)
    else $error("hit names a slot beyond the table");

  // One item is worked on at a time: the cycle after an accept is stalled.
  assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("item accepted while previous item in work");

  // A stalled result holds.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  // Reset leaves no result behind.
  assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result present after reset");

endmodule

bind port_rule_launch_time_pacer_unit prltp_checker #(
  .RULE_COUNT (RULE_COUNT)
) u_prltp_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

>>> dv/port_rule_launch_time_pacer_unit_tb.sv
// ----------------------------------------------------------------------------
// port_rule_launch_time_pacer_unit_tb: self-checking bench for the pacer
// Drives rule writes and packet items through the valid/stall handshake.
// It programs the mode and horizon registers over the APB-style port and
// compares every result item against a cycle-free model of the rule table
// and the per-slot last launch times.
// ----------------------------------------------------------------------------
import prltp_pkg::*;

module port_rule_launch_time_pacer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Multipliers of the horizon and pacing updates.
  localparam logic [63:0] BEYOND_MULT   = 64'd2;
  localparam logic [63:0] REVERSE_STEPS = 64'd20;

  // Predicts the result item of every accepted input item and keeps the
  // predictions in arrival order until the block hands back its results.
  class pacer_scoreboard;
    logic [15:0] rule_port [RULE_COUNT_DEF];
    logic [31:0] rule_pace [RULE_COUNT_DEF];
    logic [63:0] last_time [RULE_COUNT_DEF];
    ts_mode_t    mode;
    logic [31:0] horizon;
    out_item_t   launch_q [$];
    int unsigned fails;

    function new();
      foreach (rule_port[i]) begin
        rule_port[i] = '0;
        rule_pace[i] = '0;
        last_time[i] = '0;
      end
      mode    = MODE_NORMAL;
      horizon = '0;
      fails   = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [31:0] val);
      if (idx == REG_MODE) begin
        mode = ts_mode_t'(val[1:0]);
      end else begin
        horizon = val;
      end
    endfunction

    function void note_item(in_item_t it);
      out_item_t   due;
      int          slot;
      bit          stop;
      logic [63:0] last;
      logic [63:0] pace;
      logic [63:0] now;
      logic [63:0] sum;
      due  = '0;
      slot = -1;
      stop = 1'b0;
      if (it.command == CMD_WRITE_RULE) begin
        if (int'(it.rule_slot) < RULE_COUNT_DEF) begin
          rule_port[it.rule_slot] = it.rule_port_value;
          rule_pace[it.rule_slot] = it.rule_pacing_ns;
        end
      end else if (it.is_ipv4 &&
                   (it.ip_protocol == PROTO_TCP || it.ip_protocol == PROTO_UDP)) begin
        // Scan in slot order; a zero port ends the list.
        for (int i = 0; i < RULE_COUNT_DEF && !stop; i++) begin
          if (rule_port[i] == 16'd0) begin
            stop = 1'b1;
          end else if (rule_port[i] == it.dest_port) begin
            slot = i;
            stop = 1'b1;
          end
        end
        if (slot >= 0) begin
          last = last_time[slot];
          pace = {32'd0, rule_pace[slot]};
          now  = it.current_time;
          case (mode)
            MODE_BEFORE: begin
              last = now - {32'd0, horizon};
            end
            MODE_BEYOND: begin
              last = now + BEYOND_MULT * {32'd0, horizon};
            end
            MODE_REVERSE: begin
              last = (last < now) ? now + REVERSE_STEPS * pace : last - pace;
            end
            default: begin
              sum  = last + pace;
              last = (last == 64'd0) ? now : ((sum > now) ? sum : now);
            end
          endcase
          last_time[slot]  = last;
          due.launch_valid = 1'b1;
          due.launch_time  = last;
          due.hit_rule     = 3'(slot);
        end
      end
      launch_q.push_back(due);
    endfunction

    function void check_result(out_item_t got);
      out_item_t due;
      if (launch_q.size() == 0) begin
        $error("unexpected result item: launch_valid %0b launch_time %h hit_rule %0d",
               got.launch_valid, got.launch_time, got.hit_rule);
        fails++;
        return;
      end
      due = launch_q.pop_front();
      if (got.launch_valid !== due.launch_valid) begin
        $error("launch_valid: expected %0b, actual %0b", due.launch_valid, got.launch_valid);
        fails++;
      end
      if (got.launch_time !== due.launch_time) begin
        $error("launch_time: expected %h, actual %h", due.launch_time, got.launch_time);
        fails++;
      end
      if (got.hit_rule !== due.hit_rule) begin
        $error("hit_rule: expected %0d, actual %0d", due.hit_rule, got.hit_rule);
        fails++;
      end
    endfunction

    function int unsigned pending();
      return launch_q.size();
    endfunction
  endclass

  // Every input of the block starts at a known value.
  logic              clk          = 1'b0;
  logic              rst          = 1'b1;
  logic              item_valid   = 1'b0;
  logic              item_stall;
  in_item_t          item         = '0;
  logic              result_valid;
  logic              result_stall = 1'b0;
  out_item_t         result;
  logic              psel         = 1'b0;
  logic              penable      = 1'b0;
  logic              pwrite       = 1'b0;
  logic [ADDR_W-1:0] paddr        = '0;
  logic [DATA_W-1:0] pwdata       = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  pacer_scoreboard sb = new();

  // Idle percentages of each side, and a request for a long receiver
  // hold-off that the receiver process counts out on its own.
  int unsigned tx_idle_pct   = 0;
  int unsigned rx_idle_pct   = 0;
  int unsigned hold_request  = 0;

  // Ports that the rule writes draw from, so that most packets can hit.
  logic [15:0] port_pool [8];
  // Master time for the well-formed packets; it mostly moves forward.
  logic [63:0] wall_ns = 64'd1000;

  port_rule_launch_time_pacer_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #5 clk = ~clk;

  // Both handshakes are sampled in the active region right after the edge,
  // so the values seen are the ones the block saw at that edge. The input
  // item is noted before the result is checked; a result always comes after
  // its item has been accepted.
  always @(posedge clk) begin
    if (!rst) begin
      if (item_valid && !item_stall) begin
        sb.note_item(item);
      end
      if (result_valid && !result_stall) begin
        sb.check_result(result);
      end
    end
  end

  // Receiver side. Outside a hold-off it stalls at random with the current
  // percentage. A hold-off request keeps stall high for a counted stretch.
  initial begin : rx_side
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        result_stall <= 1'b1;
        hold_left--;
      end else begin
        result_stall <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  // Offers one item, after a random run of idle cycles, and returns at the
  // edge that accepts it. The payload holds still while stalled.
  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item       <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
  endtask

  // Stops offering and waits until every predicted result has come back.
  // The guard bounds the wait; anything still owed is reported at the end
  // of the run.
  task automatic settle();
    int unsigned guard;
    guard = 0;
    item_valid <= 1'b0;
    while (sb.pending() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
  endtask

  // Register write: setup cycle, then access cycle until pready. The block
  // is brought to idle first so that no item sees a half-changed setting.
  task automatic reg_write(input reg_idx_t idx, input logic [31:0] val);
    settle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(int'(idx) * 4);
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, val);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic in_item_t make_packet(logic [7:0] proto, logic [15:0] port,
                                           logic [63:0] now);
    in_item_t it;
    it              = '0;
    it.command      = CMD_CLASSIFY;
    it.is_ipv4      = 1'b1;
    it.ip_protocol  = proto;
    it.dest_port    = port;
    it.current_time = now;
    return it;
  endfunction

  function automatic in_item_t make_rule(logic [2:0] slot, logic [15:0] port,
                                         logic [31:0] pace);
    in_item_t it;
    it                 = '0;
    it.command         = CMD_WRITE_RULE;
    it.rule_slot       = slot;
    it.rule_port_value = port;
    it.rule_pacing_ns  = pace;
    return it;
  endfunction

  // Random item. Most are IPv4 TCP/UDP packets aimed at ported rules with
  // the master time moving forward; some rewrite a rule; the rest are
  // noise: non-IPv4 frames, odd protocols and fully random items. Fields
  // that the chosen command ignores carry random bits as well.
  function automatic in_item_t random_item();
    in_item_t    it;
    int unsigned pick;
    pick               = $urandom_range(99);
    it.command         = CMD_CLASSIFY;
    it.is_ipv4         = 1'b1;
    it.ip_protocol     = $urandom_range(1) ? PROTO_TCP : PROTO_UDP;
    it.dest_port       = ($urandom_range(9) < 8) ? port_pool[$urandom_range(7)]
                                                 : 16'($urandom);
    wall_ns            = wall_ns + 64'($urandom_range(4000));
    it.current_time    = ($urandom_range(19) == 0) ? {$urandom, $urandom} : wall_ns;
    it.rule_slot       = 3'($urandom);
    it.rule_port_value = 16'($urandom);
    it.rule_pacing_ns  = $urandom;
    if (pick >= 70 && pick < 82) begin
      // A rule rewrite; a zero port, which cuts the list short, is rare.
      it.command         = CMD_WRITE_RULE;
      it.rule_port_value = ($urandom_range(29) == 0) ? 16'd0 : port_pool[$urandom_range(7)];
      it.rule_pacing_ns  = ($urandom_range(9) == 0) ? $urandom : 32'($urandom_range(3000));
    end else if (pick >= 82 && pick < 88) begin
      it.is_ipv4 = 1'b0;
    end else if (pick >= 88 && pick < 94) begin
      it.ip_protocol = 8'($urandom);
    end else if (pick >= 94) begin
      it.command      = cmd_code_t'($urandom_range(1));
      it.is_ipv4      = 1'(($urandom));
      it.ip_protocol  = 8'($urandom);
      it.dest_port    = 16'($urandom);
      it.current_time = {$urandom, $urandom};
    end
    return it;
  endfunction

  // Run limit: the slowest legal run stays far below this.
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    in_item_t odd_pkt;
    foreach (port_pool[k]) begin
      port_pool[k] = 16'($urandom_range(1, 65535));
    end
    port_pool[0] = 16'hFFFF;
    port_pool[1] = 16'd1;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    tx_idle_pct = 29;
    rx_idle_pct = 60;
    reg_write(REG_MODE, 32'(MODE_NORMAL));
    reg_write(REG_HORIZON, 32'd0);

    // Directed part. With an empty table the first slot's zero port ends
    // every search, so the first packet misses.
    send_item(make_packet(PROTO_TCP, 16'd80, 64'd100));
    send_item(make_rule(3'd0, 16'd80, 32'd1000));
    send_item(make_rule(3'd1, 16'hFFFF, 32'hFFFF_FFFF));
    // Slot 7 sits behind the zero port of slot 2 and stays unreachable.
    send_item(make_rule(3'd7, 16'd443, 32'd0));
    // Normal pacing: first use takes now, then max(now, last + pacing).
    send_item(make_packet(PROTO_TCP, 16'd80, 64'd5000));
    send_item(make_packet(PROTO_UDP, 16'd80, 64'd5500));
    send_item(make_packet(PROTO_UDP, 16'd80, 64'd10000));
    // Not IPv4, and IPv4 with a protocol other than TCP or UDP.
    odd_pkt = make_packet(PROTO_TCP, 16'd80, 64'd11000);
    odd_pkt.is_ipv4 = 1'b0;
    send_item(odd_pkt);
    send_item(make_packet(8'd1, 16'd80, 64'd11000));
    send_item(make_packet(PROTO_TCP, 16'd443, 64'd12000));
    // A packet with port zero can never hit.
    send_item(make_packet(PROTO_UDP, 16'd0, 64'd12000));
    // Time at its extremes; last plus pacing wraps past zero.
    send_item(make_packet(PROTO_TCP, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF));
    send_item(make_packet(PROTO_TCP, 16'hFFFF, 64'd0));
    // Filling slot 2 makes slot 2 the first match for port 443.
    send_item(make_rule(3'd2, 16'd443, 32'd7));
    send_item(make_packet(PROTO_UDP, 16'd443, 64'd13000));

    // Horizon modes at the widest horizon, wrapping both ways.
    reg_write(REG_HORIZON, 32'hFFFF_FFFF);
    reg_write(REG_MODE, 32'(MODE_BEFORE));
    send_item(make_packet(PROTO_TCP, 16'd80, 64'd0));
    reg_write(REG_MODE, 32'(MODE_BEYOND));
    send_item(make_packet(PROTO_TCP, 16'd80, 64'hFFFF_FFFF_FFFF_FFFF));

    // Reverse mode: a last time before now jumps ahead by twenty pacing
    // steps, otherwise it steps back by one pacing interval. A rule write
    // leaves the slot's last launch time in place.
    reg_write(REG_MODE, 32'(MODE_REVERSE));
    send_item(make_packet(PROTO_TCP, 16'd80, 64'd20000));
    send_item(make_packet(PROTO_TCP, 16'd80, 64'd20000));
    send_item(make_rule(3'd0, 16'd80, 32'd3));
    send_item(make_packet(PROTO_UDP, 16'd80, 64'd20000));
    send_item(make_packet(PROTO_TCP, 16'hFFFF, 64'd0));
    send_item(make_packet(PROTO_TCP, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF));

    // Random part: fill the table, then three idling regimes over all four
    // modes, each with its own horizon.
    for (int s = 0; s < RULE_COUNT_DEF; s++) begin
      send_item(make_rule(3'(s), port_pool[s], 32'($urandom_range(3000))));
    end
    for (int r = 0; r < 3; r++) begin
      tx_idle_pct = (r == 0) ? 29 : ((r == 1) ? 60 : 0);
      rx_idle_pct = (r == 0) ? 60 : ((r == 1) ? 29 : 0);
      for (int m = 0; m < 4; m++) begin
        reg_write(REG_MODE, 32'(m));
        case ($urandom_range(3))
          0:       reg_write(REG_HORIZON, 32'd0);
          1:       reg_write(REG_HORIZON, 32'hFFFF_FFFF);
          2:       reg_write(REG_HORIZON, 32'($urandom_range(5000)));
          default: reg_write(REG_HORIZON, $urandom);
        endcase
        for (int n = 0; n < 56; n++) begin
          // A long receiver hold-off while items keep coming fills the
          // block until it stalls its input.
          if (r == 0 && m == 1 && n == 20) begin
            hold_request = 80;
          end
          // The sender pauses until every owed result has come back.
          if (r == 1 && m == 2 && n == 30) begin
            settle();
          end
          send_item(random_item());
        end
      end
    end

    settle();
    if (sb.pending() != 0) begin
      $error("%0d result items never arrived", sb.pending());
      sb.fails++;
    end
    repeat (8) @(posedge clk);
    if (sb.fails == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
